@@ rtl/kpu_pkg.sv @@
// ----------------------------------------------------------------------------
// kpu_pkg: shared types, widths and constants for the permutation unranker
// Widths of the request and result fields, the factorial function and the
// control bundle broadcast from the sequencer to the row of pool cells.
// ----------------------------------------------------------------------------
package kpu_pkg;

  localparam int unsigned SIZE_W          = 4;
  localparam int unsigned RANK_W          = 19;
  localparam int unsigned DIGIT_W         = 4;
  // Wide enough for 12! and for every multiple j * (a-1)! with j < a <= 12.
  localparam int unsigned THR_W           = 32;
  localparam int unsigned MAX_SYMBOLS_DEF = 9;

  typedef struct packed {
    logic              load;
    logic              step;
    logic [SIZE_W-1:0] avail;
  } cell_ctrl_t;

  function automatic logic [THR_W-1:0] fact_f(input int unsigned m);
    logic [THR_W-1:0] f;
    f = THR_W'(1);
    for (int unsigned i = 2; i <= m; i++) begin
      f = f * THR_W'(i);
    end
    return f;
  endfunction

endpackage

@@ rtl/kpu_cell.sv @@
// ----------------------------------------------------------------------------
// kpu_cell: one entry of the ordered pool of unused symbols
// Holds one symbol, compares the remaining rank against its own multiple of
// the current factorial, and pulls the symbol of its right neighbor when an
// entry at or left of it is removed.
// ----------------------------------------------------------------------------
module kpu_cell #(
  parameter int unsigned Index      = 0,
  parameter int unsigned MaxSymbols = kpu_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                             clk_i,
  input  kpu_pkg::cell_ctrl_t              ctrl_i,
  input  logic [kpu_pkg::RANK_W-1:0]       rem_i,
  input  logic [kpu_pkg::DIGIT_W-1:0]      next_sym_i,
  input  logic                             next_ge_i,
  output logic [kpu_pkg::DIGIT_W-1:0]      sym_o,
  output logic                             ge_o,
  output logic                             sel_o,
  output logic [kpu_pkg::THR_W-1:0]        thr_o
);

  logic [kpu_pkg::DIGIT_W-1:0] sym_q;
  logic [kpu_pkg::DIGIT_W-1:0] sym_d;
  logic [kpu_pkg::THR_W-1:0]   thr;
  logic                        in_pool;

  // Threshold Index * (avail-1)!, picked from constants by the pool size.
  always_comb begin
    thr = '0;
    for (int unsigned a = 1; a <= MaxSymbols; a++) begin
      if (ctrl_i.avail == kpu_pkg::SIZE_W'(a)) begin
        thr = kpu_pkg::THR_W'(Index) * kpu_pkg::fact_f(a - 1);
      end
    end
  end

  assign in_pool = (kpu_pkg::SIZE_W'(Index) < ctrl_i.avail);
  assign ge_o    = (Index == 0) ||
                   (in_pool && ({{(kpu_pkg::THR_W-kpu_pkg::RANK_W){1'b0}}, rem_i} >= thr));
  assign sel_o   = ge_o && !next_ge_i;
  assign thr_o   = thr;
  assign sym_o   = sym_q;

  always_comb begin
    sym_d = sym_q;
    if (ctrl_i.load) begin
      sym_d = kpu_pkg::DIGIT_W'(Index + 1);
    end else if (ctrl_i.step && !next_ge_i) begin
      // Close the gap left by the removed entry.
      sym_d = next_sym_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
  end

endmodule

@@ rtl/kth_permutation_unrank.sv @@
// ----------------------------------------------------------------------------
// kth_permutation_unrank: k-th lexicographic permutation of 1..n
// An accepted request is loaded first; each later step emits one position:
// one digit per cycle while the output is not stalled, or one error result.
// A new request is accepted only once the last result has been registered.
// Reset: asynchronous, active low; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
module kth_permutation_unrank #(
  parameter int unsigned MaxSymbols = kpu_pkg::MAX_SYMBOLS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [kpu_pkg::SIZE_W-1:0]   set_size_i,
  input  logic [kpu_pkg::RANK_W-1:0]   rank_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [kpu_pkg::DIGIT_W-1:0]  digit_o,
  output logic                         last_o,
  output logic                         bad_rank_o
);

  logic                        busy_q, busy_d;
  logic                        bad_q, bad_d;
  logic [kpu_pkg::RANK_W-1:0]  rem_q, rem_d;
  logic [kpu_pkg::SIZE_W-1:0]  avail_q, avail_d;
  logic                        out_valid_q, out_valid_d;
  logic [kpu_pkg::DIGIT_W-1:0] out_digit_q;
  logic                        out_last_q;
  logic                        out_bad_q;

  logic                        accept;
  logic                        advance;
  logic                        req_bad;
  logic [kpu_pkg::THR_W-1:0]   fact_n;
  kpu_pkg::cell_ctrl_t         ctrl;

  logic [kpu_pkg::DIGIT_W-1:0] sym  [MaxSymbols];
  logic [kpu_pkg::THR_W-1:0]   thr  [MaxSymbols];
  logic [MaxSymbols-1:0]       ge;
  logic [MaxSymbols-1:0]       sel;
  logic [kpu_pkg::DIGIT_W-1:0] sel_sym;
  logic [kpu_pkg::THR_W-1:0]   sel_thr;

  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign advance    = busy_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    fact_n = '0;
    for (int unsigned m = 1; m <= MaxSymbols; m++) begin
      if (set_size_i == kpu_pkg::SIZE_W'(m)) begin
        fact_n = kpu_pkg::fact_f(m);
      end
    end
  end

  assign req_bad = (set_size_i == '0) ||
                   (set_size_i > kpu_pkg::SIZE_W'(MaxSymbols)) ||
                   (rank_i == '0) ||
                   ({{(kpu_pkg::THR_W-kpu_pkg::RANK_W){1'b0}}, rank_i} > fact_n);

  assign ctrl.load  = accept;
  assign ctrl.step  = advance && !bad_q;
  assign ctrl.avail = avail_q;

  for (genvar j = 0; j < MaxSymbols; j++) begin : g_cell
    logic [kpu_pkg::DIGIT_W-1:0] nsym;
    logic                        nge;
    if (j == MaxSymbols - 1) begin : g_end
      assign nsym = '0;
      assign nge  = 1'b0;
    end else begin : g_mid
      assign nsym = sym[j+1];
      assign nge  = ge[j+1];
    end
    kpu_cell #(
      .Index     (j),
      .MaxSymbols(MaxSymbols)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (ctrl),
      .rem_i     (rem_q),
      .next_sym_i(nsym),
      .next_ge_i (nge),
      .sym_o     (sym[j]),
      .ge_o      (ge[j]),
      .sel_o     (sel[j]),
      .thr_o     (thr[j])
    );
  end

  always_comb begin
    sel_sym = '0;
    sel_thr = '0;
    for (int unsigned j = 0; j < MaxSymbols; j++) begin
      if (sel[j]) begin
        sel_sym = sel_sym | sym[j];
        sel_thr = sel_thr | thr[j];
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    bad_d       = bad_q;
    rem_d       = rem_q;
    avail_d     = avail_q;
    out_valid_d = out_valid_q;
    if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d  = 1'b1;
      bad_d   = req_bad;
      rem_d   = rank_i - kpu_pkg::RANK_W'(1);
      avail_d = set_size_i;
    end else if (advance) begin
      out_valid_d = 1'b1;
      rem_d       = rem_q - sel_thr[kpu_pkg::RANK_W-1:0];
      avail_d     = avail_q - kpu_pkg::SIZE_W'(1);
      if (bad_q || (avail_q == kpu_pkg::SIZE_W'(1))) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bad_q   <= bad_d;
    rem_q   <= rem_d;
    avail_q <= avail_d;
    if (advance) begin
      out_digit_q <= bad_q ? '0 : sel_sym;
      out_last_q  <= bad_q || (avail_q == kpu_pkg::SIZE_W'(1));
      out_bad_q   <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit_o     = out_digit_q;
  assign last_o      = out_last_q;
  assign bad_rank_o  = out_bad_q;

`ifndef SYNTHESIS
  a_sel_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !bad_q |-> $onehot(sel))
    else $error("pool selection is not one-hot");

  a_avail_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !bad_q |-> avail_q != '0)
    else $error("sequencer busy with empty pool");

  a_err_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_bad_q |-> out_last_q && out_digit_q == '0)
    else $error("error result without last or with nonzero digit");

  a_digit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_bad_q |-> out_digit_q != '0)
    else $error("valid result carries digit zero");
`endif

endmodule

@@ tb/sv/kth_permutation_unrank_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kth_permutation_unrank_tb: self-checking bench for the permutation unranker
// Sends set size / rank requests and predicts the digit stream of every
// request in a scoreboard. It checks each result in order, with random gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module kth_permutation_unrank_tb;

  localparam int unsigned MAX_SYMBOLS = kpu_pkg::MAX_SYMBOLS_DEF;
  localparam int unsigned IDLE_LIMIT  = 2000;
  localparam int unsigned RAND_ITEMS  = 136;

  typedef struct packed {
    logic [kpu_pkg::DIGIT_W-1:0] digit;
    logic                        last;
    logic                        bad;
  } digit_result_t;

  class unrank_scoreboard;
    digit_result_t expected_q[$];
    int unsigned   mismatches;

    function logic [31:0] perm_count(int unsigned m);
      logic [31:0] f;
      f = 32'd1;
      for (int unsigned i = 2; i <= m; i++) begin
        f = f * i;
      end
      return f;
    endfunction

    function void queue_result(logic [kpu_pkg::DIGIT_W-1:0] digit, logic last, logic bad);
      digit_result_t item;
      item.digit = digit;
      item.last  = last;
      item.bad   = bad;
      expected_q = {expected_q, item};
    endfunction

    // Expand one accepted request into its expected digit stream.
    function void note_request(logic [kpu_pkg::SIZE_W-1:0] n,
                               logic [kpu_pkg::RANK_W-1:0] k);
      logic [kpu_pkg::DIGIT_W-1:0] pool[$];
      logic [31:0]                 r;
      logic [31:0]                 f;
      logic [31:0]                 x;
      int unsigned                 avail;
      if (n == 0 || n > MAX_SYMBOLS || k == 0 || k > perm_count(n)) begin
        queue_result('0, 1'b1, 1'b1);
        return;
      end
      for (int unsigned i = 1; i <= n; i++) begin
        pool = {pool, kpu_pkg::DIGIT_W'(i)};
      end
      r = 32'(k) - 32'd1;
      for (int unsigned i = 0; i < n; i++) begin
        avail = pool.size();
        f = perm_count(avail - 1);
        x = r / f;
        r = r % f;
        if (x >= avail) x = avail - 1;
        queue_result(pool[x], (i + 1 == n), 1'b0);
        pool.delete(x);
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t mismatch: %s", $time, msg);
    endfunction

    function void check_result(logic [kpu_pkg::DIGIT_W-1:0] digit, logic last, logic bad);
      digit_result_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result digit=%0d last=%0b bad_rank=%0b",
                         digit, last, bad));
        return;
      end
      want = expected_q.pop_front();
      if (digit !== want.digit || last !== want.last || bad !== want.bad) begin
        report($sformatf("digit exp %0d got %0d, last exp %0b got %0b, bad_rank exp %0b got %0b",
                         want.digit, digit, want.last, last, want.bad, bad));
      end
    endfunction
  endclass

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_stall_o;
  logic [kpu_pkg::SIZE_W-1:0]  set_size_i  = '0;
  logic [kpu_pkg::RANK_W-1:0]  rank_i      = '0;
  logic                        out_valid_o;
  logic                        out_stall_i = 1'b0;
  logic [kpu_pkg::DIGIT_W-1:0] digit_o;
  logic                        last_o;
  logic                        bad_rank_o;

  unrank_scoreboard sb = new;
  bit               in_calm   = 1'b0;
  bit               out_calm  = 1'b0;
  int unsigned      stall_left = 0;
  int unsigned      idle_cycles = 0;

  kth_permutation_unrank dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .set_size_i  (set_size_i),
    .rank_i      (rank_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .digit_o     (digit_o),
    .last_o      (last_o),
    .bad_rank_o  (bad_rank_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (!out_calm && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    out_stall_i <= (stall_left != 0);
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_request(set_size_i, rank_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(digit_o, last_o, bad_rank_o);
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Called and returns at a falling edge; valid stays high for a back-to-back request.
  task automatic send_request(input logic [kpu_pkg::SIZE_W-1:0] n,
                              input logic [kpu_pkg::RANK_W-1:0] k);
    int unsigned gap;
    gap = (in_calm || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    set_size_i <= n;
    rank_i     <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    logic [kpu_pkg::SIZE_W-1:0] n;
    logic [kpu_pkg::RANK_W-1:0] k;
    int unsigned                pick;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: size and rank extremes, out-of-range sizes and ranks.
    send_request(0, 1);
    send_request(10, 1);
    send_request(15, '1);
    send_request(1, 0);
    send_request(1, 1);
    send_request(1, 2);
    send_request(2, 1);
    send_request(2, 2);
    send_request(2, 3);
    for (int unsigned r = 0; r <= 7; r++) begin
      send_request(3, kpu_pkg::RANK_W'(r));
    end
    send_request(8, 40320);
    send_request(8, 40321);
    send_request(9, 0);
    send_request(9, 1);
    send_request(9, 362880);
    send_request(9, 362881);
    send_request(9, '1);
    send_request(4, 13);
    wait_drained();

    for (int unsigned i = 0; i < RAND_ITEMS; i++) begin
      if (i % 20 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      if (i == RAND_ITEMS / 2) wait_drained();
      pick = $urandom_range(0, 99);
      n = kpu_pkg::SIZE_W'($urandom_range(1, MAX_SYMBOLS));
      if (pick < 80) begin
        k = kpu_pkg::RANK_W'($urandom_range(1, sb.perm_count(n)));
      end else if (pick < 90) begin
        k = kpu_pkg::RANK_W'(sb.perm_count(n) + $urandom_range(0, 1));
      end else begin
        n = kpu_pkg::SIZE_W'($urandom);
        k = kpu_pkg::RANK_W'($urandom);
      end
      send_request(n, k);
    end

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kpu_pkg.sv
rtl/kpu_cell.sv
rtl/kth_permutation_unrank.sv
tb/sv/kth_permutation_unrank_tb.sv
